// ----- src/egb_pkg.sv -----
// Shared constants, types and state encoding for the epsilon-greedy bandit agent.
// Has no dependencies; every other file of the block uses it by scoped names.
package egb_pkg;

  localparam int NUM_ARMS    = 16;
  localparam int ARM_W       = $clog2(NUM_ARMS);
  localparam int NARM_W      = ARM_W + 1;
  localparam int VALUE_W     = 24;
  localparam int COUNT_W     = 16;
  localparam int DIFF_W      = VALUE_W + 1;
  localparam int DRAW_W      = 16;
  localparam int OUT_VALUE_W = 24;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARMS       = 2'd3;

  // Reset values: step size 0.1 in Q0.16, ten arms in use.
  localparam logic [DRAW_W-1:0] STEP_SIZE_RESET = 16'd6554;
  localparam logic [4:0]        ARMS_RESET      = 5'd10;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD_READ,
    S_UPD_CALC,
    S_UPD_DIV,
    S_UPD_WRITE,
    S_SCAN,
    S_PICK_SETUP,
    S_PICK,
    S_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic upd_read;
    logic upd_mul;
    logic div_start;
    logic upd_write;
    logic scan_step;
    logic pick_setup;
    logic pick_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic upd_needed;
    logic fixed_mode;
    logic den_zero;
    logic div_done;
    logic scan_last;
    logic explore;
    logic pick_hit;
    logic out_free;
  } stat_t;

endpackage

// ----- src/egb_if.sv -----
// Valid/ready channel interfaces for the agent's input and result beats.
// Depends on egb_pkg for field widths.
interface egb_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       reward_valid;
  logic signed [egb_pkg::VALUE_W-1:0]         reward;
  logic [egb_pkg::DRAW_W-1:0]                 explore_draw;
  logic [egb_pkg::DRAW_W-1:0]                 arm_draw;
  logic [egb_pkg::DRAW_W-1:0]                 tie_draw;

  modport source (output valid, reward_valid, reward, explore_draw, arm_draw, tie_draw,
                  input ready);
  modport sink (input valid, reward_valid, reward, explore_draw, arm_draw, tie_draw,
                output ready);
endinterface

interface egb_out_if;
  logic                                       valid;
  logic                                       ready;
  logic [egb_pkg::ARM_W-1:0]                  chosen_arm;
  logic                                       explored;
  logic signed [egb_pkg::OUT_VALUE_W-1:0]     best_estimate;

  modport source (output valid, chosen_arm, explored, best_estimate, input ready);
  modport sink (input valid, chosen_arm, explored, best_estimate, output ready);
endinterface

// ----- src/epsilon_greedy_bandit_agent.sv -----
// Top level of the epsilon-greedy bandit agent: channels, controller, datapath.
// Depends on egb_pkg, egb_if, egb_div, egb_dp and egb_ctrl.
//
// The agent takes one input beat at a time on req and returns exactly one result
// beat on rsp for it. A beat first applies its reward, when flagged, to the arm
// chosen by the previous beat, then walks the arms in use once to find the best
// estimate and its tie count, and, unless it explores, walks them again to find
// the selected tied arm. A reward in 1/count mode goes through a restoring
// divider that produces one quotient bit per cycle. The result sits in an
// output register, so req is ready again as soon as the result is loaded,
// even while rsp is stalled. Configuration registers are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// agent is idle, as the block itself does not enforce it. They take effect
// on the next beat.
module epsilon_greedy_bandit_agent (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [egb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [egb_pkg::CFG_W-1:0]         cfg_data,
  egb_in_if.sink                            req,
  egb_out_if.source                         rsp
);

  egb_pkg::cmd_t  cmd;
  egb_pkg::stat_t stat;

  egb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  egb_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .stat              (stat),
    .in_reward_valid   (req.reward_valid),
    .in_reward         (req.reward),
    .in_explore_draw   (req.explore_draw),
    .in_arm_draw       (req.arm_draw),
    .in_tie_draw       (req.tie_draw),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_chosen_arm    (rsp.chosen_arm),
    .out_explored      (rsp.explored),
    .out_best_estimate (rsp.best_estimate)
  );

  // Once a beat is taken, the agent is busy with it and not ready in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("input accepted again right after a beat");

  // A result is only loaded when the output register is free to take it.
  a_commit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp.valid || rsp.ready))
    else $error("result committed over a waiting result");

  // An estimate is written only for a reward that applies to a previous arm.
  a_write_needs_reward: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_write |-> stat.upd_needed)
    else $error("estimate written without a valid reward");

endmodule

// ----- src/egb_div.sv -----
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on egb_pkg for operand widths.
module egb_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [egb_pkg::DIFF_W-1:0]        dividend,
  input  logic [egb_pkg::COUNT_W-1:0]       divisor,
  output logic                              done,
  output logic [egb_pkg::DIFF_W-1:0]        quotient
);

  localparam int STEP_W = $clog2(egb_pkg::DIFF_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(egb_pkg::DIFF_W - 1);

  logic                           busy;
  logic [STEP_W-1:0]              step;
  logic [egb_pkg::COUNT_W-1:0]    rem;
  logic [egb_pkg::COUNT_W-1:0]    den;
  logic [egb_pkg::DIFF_W-1:0]     quo;
  logic [egb_pkg::COUNT_W:0]      trial;
  logic                           fits;

  assign trial    = {rem, quo[egb_pkg::DIFF_W-1]};
  assign fits     = trial >= {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= egb_pkg::COUNT_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[egb_pkg::COUNT_W-1:0];
      end
      quo <= {quo[egb_pkg::DIFF_W-2:0], fits};
    end
  end

endmodule

// ----- src/egb_dp.sv -----
// Datapath: configuration, estimate and count registers, update arithmetic,
// arm scan and output register. Depends on egb_pkg and egb_div.
module egb_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [egb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [egb_pkg::CFG_W-1:0]             cfg_data,
  input  egb_pkg::cmd_t                         cmd,
  output egb_pkg::stat_t                        stat,
  input  logic                                  in_reward_valid,
  input  logic signed [egb_pkg::VALUE_W-1:0]    in_reward,
  input  logic [egb_pkg::DRAW_W-1:0]            in_explore_draw,
  input  logic [egb_pkg::DRAW_W-1:0]            in_arm_draw,
  input  logic [egb_pkg::DRAW_W-1:0]            in_tie_draw,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [egb_pkg::ARM_W-1:0]             out_chosen_arm,
  output logic                                  out_explored,
  output logic signed [egb_pkg::OUT_VALUE_W-1:0] out_best_estimate
);

  localparam int VW    = egb_pkg::VALUE_W;
  localparam int DW    = egb_pkg::DIFF_W;
  localparam int SUM_W = VW + 2;
  localparam int AW    = egb_pkg::ARM_W;
  localparam int NW    = egb_pkg::NARM_W;
  localparam int CW    = egb_pkg::COUNT_W;
  localparam int RW    = egb_pkg::DRAW_W;
  localparam logic signed [VW-1:0]    VALUE_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_HI    = SUM_W'((64'sd1 <<< (VW-1)) - 1);
  localparam logic signed [SUM_W-1:0] SUM_LO    = SUM_W'(-(64'sd1 <<< (VW-1)));
  localparam logic [NW-1:0] ARMS_MAX = NW'(egb_pkg::NUM_ARMS);

  // Configuration registers.
  logic [RW-1:0]  epsilon;
  logic           const_step;
  logic [RW-1:0]  step_amt;
  logic [4:0]     arms_in_use;
  logic [NW-1:0]  n_eff;

  // Agent state.
  logic signed [VW-1:0] est [egb_pkg::NUM_ARMS];
  logic [CW-1:0]        cnt [egb_pkg::NUM_ARMS];
  logic [AW-1:0]        last_arm;
  logic                 have_last;

  // Latched input beat.
  logic                 rwd_valid;
  logic signed [VW-1:0] reward;
  logic [RW-1:0]        explore_draw;
  logic [RW-1:0]        arm_draw;
  logic [RW-1:0]        tie_draw;

  // Working registers.
  logic signed [VW-1:0] est_old;
  logic                 diff_neg;
  logic [DW-1:0]        mag;
  logic [CW-1:0]        den;
  logic [DW-1:0]        dmag;
  logic [AW-1:0]        idx;
  logic signed [VW-1:0] best;
  logic [NW-1:0]        ties;
  logic [NW-1:0]        pick;
  logic [NW-1:0]        seen;
  logic [AW-1:0]        chosen;
  logic                 explored;

  logic [AW-1:0]         est_addr;
  logic [AW-1:0]         cnt_addr;
  logic signed [VW-1:0]  est_rd;
  logic [CW-1:0]         cnt_rd;
  logic signed [DW-1:0]  diff;
  logic [DW+RW-1:0]      step_prod;
  logic [RW+NW-1:0]      arm_prod;
  logic [RW+NW-1:0]      pick_prod;
  logic signed [SUM_W-1:0] delta;
  logic signed [SUM_W-1:0] sum;
  logic signed [VW-1:0]  est_new;
  logic                  div_done;
  logic [DW-1:0]         quo;
  logic                  explore_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon     <= '0;
      const_step  <= 1'b0;
      step_amt    <= egb_pkg::STEP_SIZE_RESET;
      arms_in_use <= egb_pkg::ARMS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        egb_pkg::CFG_EPSILON:    epsilon     <= cfg_data[RW-1:0];
        egb_pkg::CFG_FIXED_STEP: const_step  <= cfg_data[0];
        egb_pkg::CFG_STEP_SIZE:  step_amt    <= cfg_data[RW-1:0];
        egb_pkg::CFG_ARMS:       arms_in_use <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (arms_in_use == 5'd0) begin
      n_eff = NW'(1);
    end else if (NW'(arms_in_use) > ARMS_MAX) begin
      n_eff = ARMS_MAX;
    end else begin
      n_eff = NW'(arms_in_use);
    end
  end

  assign est_addr = cmd.upd_read ? last_arm : idx;
  assign cnt_addr = cmd.upd_read ? last_arm : chosen;
  assign est_rd   = est[est_addr];
  assign cnt_rd   = cnt[cnt_addr];

  assign diff      = DW'(reward) - DW'(est_rd);
  assign step_prod = mag * step_amt;
  assign arm_prod  = arm_draw * n_eff;
  assign pick_prod = tie_draw * ties;
  assign explore_now = explore_draw < epsilon;

  always_comb begin
    delta = diff_neg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    sum   = SUM_W'(est_old) + delta;
    if (sum > SUM_HI) begin
      est_new = SUM_HI[VW-1:0];
    end else if (sum < SUM_LO) begin
      est_new = SUM_LO[VW-1:0];
    end else begin
      est_new = sum[VW-1:0];
    end
  end

  egb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  // Estimates, counts and the previous-arm record.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < egb_pkg::NUM_ARMS; i++) begin
        est[i] <= '0;
        cnt[i] <= '0;
      end
      last_arm  <= '0;
      have_last <= 1'b0;
    end else begin
      if (cmd.upd_write) begin
        est[last_arm] <= est_new;
      end
      if (cmd.commit) begin
        if (cnt_rd != {CW{1'b1}}) begin
          cnt[chosen] <= cnt_rd + 1'b1;
        end
        last_arm  <= chosen;
        have_last <= 1'b1;
      end
    end
  end

  // Beat capture and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rwd_valid    <= in_reward_valid;
      reward       <= in_reward;
      explore_draw <= in_explore_draw;
      arm_draw     <= in_arm_draw;
      tie_draw     <= in_tie_draw;
      idx          <= '0;
      best         <= VALUE_MIN;
      ties         <= '0;
    end
    if (cmd.upd_read) begin
      est_old  <= est_rd;
      diff_neg <= diff[DW-1];
      mag      <= diff[DW-1] ? DW'(-diff) : DW'(diff);
      den      <= cnt_rd;
    end
    if (cmd.upd_mul) begin
      dmag <= step_prod[DW+RW-1:RW];
    end else if (div_done) begin
      dmag <= quo;
    end
    if (cmd.scan_step) begin
      if (est_rd > best) begin
        best <= est_rd;
        ties <= NW'(1);
      end else if (est_rd == best) begin
        ties <= ties + 1'b1;
      end
      idx <= idx + 1'b1;
    end
    if (cmd.pick_setup) begin
      explored <= explore_now;
      pick     <= pick_prod[RW+NW-1:RW];
      chosen   <= explore_now ? arm_prod[RW+AW-1:RW] : '0;
      idx      <= '0;
      seen     <= '0;
    end
    if (cmd.pick_step) begin
      if (est_rd == best) begin
        if (seen == pick) begin
          chosen <= idx;
        end
        seen <= seen + 1'b1;
      end
      idx <= idx + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_chosen_arm    <= chosen;
      out_explored      <= explored;
      out_best_estimate <= best;
    end
  end

  always_comb begin
    stat.upd_needed = rwd_valid && have_last;
    stat.fixed_mode = const_step;
    stat.den_zero   = (den == '0);
    stat.div_done   = div_done;
    stat.scan_last  = ({1'b0, idx} == (n_eff - 1'b1));
    stat.explore    = explore_now;
    stat.pick_hit   = (est_rd == best) && (seen == pick);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

// ----- src/egb_ctrl.sv -----
// Controller state machine sequencing the update, scan, pick and commit steps.
// Depends on egb_pkg for the state, command and status types.
module egb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  egb_pkg::stat_t  stat,
  output egb_pkg::cmd_t   cmd
);

  egb_pkg::state_t state;
  egb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= egb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      egb_pkg::S_IDLE: begin
        if (in_valid && in_ready) state_next = egb_pkg::S_UPD_READ;
      end
      egb_pkg::S_UPD_READ: begin
        state_next = stat.upd_needed ? egb_pkg::S_UPD_CALC : egb_pkg::S_SCAN;
      end
      egb_pkg::S_UPD_CALC: begin
        if (stat.fixed_mode) begin
          state_next = egb_pkg::S_UPD_WRITE;
        end else if (stat.den_zero) begin
          state_next = egb_pkg::S_SCAN;
        end else begin
          state_next = egb_pkg::S_UPD_DIV;
        end
      end
      egb_pkg::S_UPD_DIV: begin
        if (stat.div_done) state_next = egb_pkg::S_UPD_WRITE;
      end
      egb_pkg::S_UPD_WRITE: state_next = egb_pkg::S_SCAN;
      egb_pkg::S_SCAN: begin
        if (stat.scan_last) state_next = egb_pkg::S_PICK_SETUP;
      end
      egb_pkg::S_PICK_SETUP: begin
        state_next = stat.explore ? egb_pkg::S_COMMIT : egb_pkg::S_PICK;
      end
      egb_pkg::S_PICK: begin
        if (stat.pick_hit || stat.scan_last) state_next = egb_pkg::S_COMMIT;
      end
      egb_pkg::S_COMMIT: begin
        if (stat.out_free) state_next = egb_pkg::S_IDLE;
      end
      default: state_next = egb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      egb_pkg::S_IDLE: begin
        in_ready    = !rst;
        cmd.load_in = in_valid && !rst;
      end
      egb_pkg::S_UPD_READ:   cmd.upd_read = stat.upd_needed;
      egb_pkg::S_UPD_CALC: begin
        cmd.upd_mul   = stat.fixed_mode;
        cmd.div_start = !stat.fixed_mode && !stat.den_zero;
      end
      egb_pkg::S_UPD_DIV:    ;
      egb_pkg::S_UPD_WRITE:  cmd.upd_write  = 1'b1;
      egb_pkg::S_SCAN:       cmd.scan_step  = 1'b1;
      egb_pkg::S_PICK_SETUP: cmd.pick_setup = 1'b1;
      egb_pkg::S_PICK:       cmd.pick_step  = 1'b1;
      egb_pkg::S_COMMIT:     cmd.commit     = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ----- bench/epsilon_greedy_bandit_agent_tb.sv -----
// Self-checking testbench for the epsilon-greedy bandit agent.
// Uses egb_pkg, egb_in_if and egb_out_if from the RTL and the agent top level.
`timescale 1ns / 1ps

module epsilon_greedy_bandit_agent_tb;

  localparam int VALUE_W     = egb_pkg::VALUE_W;
  localparam int DRAW_W      = egb_pkg::DRAW_W;
  localparam int COUNT_W     = egb_pkg::COUNT_W;
  localparam int ARM_W       = egb_pkg::ARM_W;
  localparam int OUT_VALUE_W = egb_pkg::OUT_VALUE_W;
  localparam int CFG_IDX_W   = egb_pkg::CFG_IDX_W;
  localparam int CFG_W       = egb_pkg::CFG_W;
  localparam int NUM_ARMS    = egb_pkg::NUM_ARMS;

  localparam int     RESET_CYCLES = 10;
  // This drain outlasts the slowest beat with 16 arms.
  localparam int     DRAIN_CYCLES = 100;
  // Roughly 1250 pulls at the slowest beat with the longest idling stay well
  // under this limit.
  localparam longint CYCLE_LIMIT  = 1_000_000;
  localparam int     MAX_REPORTS  = 10;

  localparam logic signed [VALUE_W-1:0] REWARD_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] REWARD_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [DRAW_W-1:0]         DRAW_MAX   = '1;
  localparam logic [COUNT_W-1:0]        PULLS_MAX  = '1;

  // One pull request as it travels on the input channel.
  typedef struct packed {
    logic                      reward_valid;
    logic signed [VALUE_W-1:0] reward;
    logic [DRAW_W-1:0]         explore_draw;
    logic [DRAW_W-1:0]         arm_draw;
    logic [DRAW_W-1:0]         tie_draw;
  } pull_t;

  // One arm choice as it comes back on the result channel.
  typedef struct packed {
    logic [ARM_W-1:0]              chosen_arm;
    logic                          explored;
    logic signed [OUT_VALUE_W-1:0] best_estimate;
  } choice_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  egb_in_if  req_ch ();
  egb_out_if rsp_ch ();

  epsilon_greedy_bandit_agent u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #6 clk = ~clk;

  // Shadow of the agent: arm estimates, pull counts, the arm that the next
  // reward belongs to, and the four configuration registers.
  logic signed [VALUE_W-1:0] arm_value [NUM_ARMS];
  logic [COUNT_W-1:0]        arm_pulls [NUM_ARMS];
  logic [ARM_W-1:0]          last_arm;
  logic                      have_last;
  logic [DRAW_W-1:0]         eps_q;
  logic                      const_step;
  logic [DRAW_W-1:0]         step_q;
  logic [4:0]                arms_cfg;

  choice_t     expected_choices [$];
  int unsigned fail_count = 0;
  int unsigned result_count = 0;
  longint      cycle_count = 0;
  bit          gaps_on;
  bit          stalls_on;
  int unsigned stall_left;

  // Clamp a wide value into the signed range of a w-bit estimate.
  function automatic longint clamp_value(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Advances the shadow by one accepted pull and returns the arm choice that
  // the agent must report for it.
  function automatic choice_t predict_choice(pull_t p);
    choice_t c;
    longint  cur;
    longint  diff;
    longint  mag;
    longint  dmag;
    longint  best;
    bit      neg;
    bit      skip;
    int      n;
    int      ties;
    int      pick;
    int      seen;
    int      arm;

    // The reward belongs to the arm picked by the previous pull; before any
    // pick there is no such arm and the reward is dropped.
    if (p.reward_valid && have_last) begin
      cur  = arm_value[last_arm];
      diff = $signed(p.reward) - cur;
      neg  = diff < 0;
      mag  = neg ? -diff : diff;
      skip = 1'b0;
      dmag = 0;
      if (const_step) begin
        dmag = (mag * longint'(step_q)) >>> 16;
      end else if (arm_pulls[last_arm] == '0) begin
        skip = 1'b1;
      end else begin
        dmag = mag / longint'(arm_pulls[last_arm]);
      end
      if (!skip) begin
        arm_value[last_arm] = VALUE_W'(clamp_value(cur + (neg ? -dmag : dmag), VALUE_W));
      end
    end

    // Out-of-range arm counts fold into 1 .. NUM_ARMS.
    n = int'(arms_cfg);
    if (n < 1) n = 1;
    if (n > NUM_ARMS) n = NUM_ARMS;

    best = arm_value[0];
    for (int i = 1; i < n; i++) begin
      if (arm_value[i] > best) best = arm_value[i];
    end
    ties = 0;
    for (int i = 0; i < n; i++) begin
      if (arm_value[i] == best) ties++;
    end

    c.explored = p.explore_draw < eps_q;
    arm = 0;
    if (c.explored) begin
      arm = int'((longint'(p.arm_draw) * n) >>> 16);
    end else begin
      // Take the pick-th tied arm, counting from arm 0 upward.
      pick = int'((longint'(p.tie_draw) * ties) >>> 16);
      seen = 0;
      for (int i = 0; i < n; i++) begin
        if (arm_value[i] == best) begin
          if (seen == pick) begin
            arm = i;
            break;
          end
          seen++;
        end
      end
    end

    if (arm_pulls[arm] != PULLS_MAX) arm_pulls[arm] = arm_pulls[arm] + 1'b1;
    last_arm  = ARM_W'(arm);
    have_last = 1'b1;

    c.chosen_arm    = ARM_W'(arm);
    c.best_estimate = OUT_VALUE_W'(clamp_value(best, OUT_VALUE_W));
    return c;
  endfunction

  function automatic pull_t make_pull(bit rv, logic signed [VALUE_W-1:0] r,
                                      logic [DRAW_W-1:0] ed, logic [DRAW_W-1:0] ad,
                                      logic [DRAW_W-1:0] td);
    pull_t p;
    p.reward_valid = rv;
    p.reward       = r;
    p.explore_draw = ed;
    p.arm_draw     = ad;
    p.tie_draw     = td;
    return p;
  endfunction

  // Draws lean on both ends of the range so that the scaled picks hit the
  // first and the last arm often.
  function automatic logic [DRAW_W-1:0] random_draw();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DRAW_MAX;
      default: return DRAW_W'($urandom);
    endcase
  endfunction

  function automatic pull_t random_pull();
    pull_t p;
    int    r;
    p.reward_valid = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 3))
      0: p.reward = VALUE_W'($urandom);
      1: begin
        // A short menu of rewards makes estimates land on equal values, which
        // keeps the tie walk busy.
        case ($urandom_range(0, 3))
          0: p.reward = '0;
          1: p.reward = VALUE_W'(65536);
          2: p.reward = VALUE_W'(-65536);
          default: p.reward = VALUE_W'(32768);
        endcase
      end
      2: begin
        r = int'($urandom_range(0, 131072)) - 65536;
        p.reward = r[VALUE_W-1:0];
      end
      default: p.reward = $urandom_range(0, 1) ? REWARD_MAX : REWARD_MIN;
    endcase
    p.explore_draw = random_draw();
    p.arm_draw     = random_draw();
    p.tie_draw     = random_draw();
    return p;
  endfunction

  // Offers one pull beat and returns at the edge where it is taken. Valid is
  // left high, so back-to-back beats keep it up; a gap or a pause lowers it.
  task automatic send_pull(pull_t p);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.reward_valid <= p.reward_valid;
    req_ch.reward       <= p.reward;
    req_ch.explore_draw <= p.explore_draw;
    req_ch.arm_draw     <= p.arm_draw;
    req_ch.tie_draw     <= p.tie_draw;
    do @(posedge clk); while (!req_ch.ready);
    expected_choices.insert(expected_choices.size(), predict_choice(p));
  endtask

  // Stops offering beats, waits for every outstanding choice, then lets the
  // agent run out whatever is still in flight.
  task automatic settle_agent();
    req_ch.valid <= 1'b0;
    while (expected_choices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      egb_pkg::CFG_EPSILON:    eps_q      = data[DRAW_W-1:0];
      egb_pkg::CFG_FIXED_STEP: const_step = data[0];
      egb_pkg::CFG_STEP_SIZE:  step_q     = data[DRAW_W-1:0];
      egb_pkg::CFG_ARMS:       arms_cfg   = data[4:0];
      default: ;
    endcase
  endtask

  task automatic program_agent(logic [DRAW_W-1:0] eps, logic fixed, logic [DRAW_W-1:0] step,
                               logic [4:0] arms);
    write_reg(egb_pkg::CFG_EPSILON, CFG_W'(eps));
    write_reg(egb_pkg::CFG_FIXED_STEP, CFG_W'(fixed));
    write_reg(egb_pkg::CFG_STEP_SIZE, CFG_W'(step));
    write_reg(egb_pkg::CFG_ARMS, CFG_W'(arms));
  endtask

  // Reset settings: greedy only, 1/count steps, ten arms. The first beat
  // carries a reward although no arm has been chosen yet, so it must be
  // dropped. Extreme rewards push arm 0 to the top and arm 9 to the bottom.
  task automatic test_greedy_updates();
    send_pull(make_pull(1, REWARD_MAX, DRAW_MAX, DRAW_MAX, '0));
    send_pull(make_pull(1, REWARD_MAX, '0, '0, DRAW_MAX));
    send_pull(make_pull(1, REWARD_MIN, '0, '0, DRAW_MAX));
    send_pull(make_pull(1, REWARD_MIN, '0, '0, 16'h8000));
    send_pull(make_pull(0, REWARD_MAX, '0, '0, '0));
    send_pull(make_pull(1, '0, '0, '0, DRAW_MAX));
    settle_agent();
  endtask

  // Full exploration with the largest constant step. An explore draw of all
  // ones never explores, even at the largest epsilon. A step of zero freezes
  // the estimates, and a step of one moves them by the smallest amount.
  task automatic test_exploration();
    program_agent(DRAW_MAX, 1'b1, DRAW_MAX, 5'd16);
    send_pull(make_pull(0, '0, '0, '0, '0));
    send_pull(make_pull(1, REWARD_MAX, '0, DRAW_MAX, '0));
    send_pull(make_pull(1, REWARD_MIN, 16'hFFFE, 16'h8000, '0));
    send_pull(make_pull(1, REWARD_MAX, DRAW_MAX, '0, DRAW_MAX));
    send_pull(make_pull(1, REWARD_MIN, DRAW_MAX, DRAW_MAX, '0));
    settle_agent();
    program_agent(16'h8000, 1'b1, '0, 5'd16);
    send_pull(make_pull(1, REWARD_MAX, 16'h7FFF, 16'h1000, '0));
    send_pull(make_pull(1, REWARD_MIN, 16'h8000, 16'h1000, DRAW_MAX));
    settle_agent();
    write_reg(egb_pkg::CFG_STEP_SIZE, CFG_W'(1));
    send_pull(make_pull(1, REWARD_MAX, 16'h8000, '0, 16'h5555));
    settle_agent();
  endtask

  // An arm count of zero behaves as one arm; counts above the arm total
  // behave as all arms.
  task automatic test_arm_limits();
    program_agent(16'h8000, 1'b0, 16'd6554, 5'd0);
    send_pull(make_pull(1, VALUE_W'(65536), '0, DRAW_MAX, DRAW_MAX));
    send_pull(make_pull(1, VALUE_W'(-65536), DRAW_MAX, '0, DRAW_MAX));
    settle_agent();
    write_reg(egb_pkg::CFG_ARMS, CFG_W'(17));
    send_pull(make_pull(0, '0, '0, DRAW_MAX, '0));
    send_pull(make_pull(1, REWARD_MAX, DRAW_MAX, '0, DRAW_MAX));
    settle_agent();
    write_reg(egb_pkg::CFG_ARMS, CFG_W'(31));
    send_pull(make_pull(1, REWARD_MIN, '0, DRAW_MAX, DRAW_MAX));
    send_pull(make_pull(0, '0, DRAW_MAX, '0, DRAW_MAX));
    settle_agent();
  endtask

  // With a single arm every beat pulls arm 0, so its count climbs. Rewards in
  // 1/count mode afterwards divide by a count well above one.
  task automatic test_single_arm();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    program_agent('0, 1'b0, 16'd6554, 5'd1);
    for (int i = 0; i < 40; i++) begin
      send_pull(make_pull(0, '0, random_draw(), random_draw(), random_draw()));
    end
    send_pull(make_pull(1, REWARD_MAX, '0, '0, '0));
    send_pull(make_pull(1, REWARD_MIN, '0, '0, '0));
    send_pull(make_pull(1, REWARD_MAX, '0, '0, '0));
    settle_agent();
  endtask

  // Random pulls across a series of random settings. Every fourth phase runs
  // without idling on either side, and so does the last one.
  task automatic test_random_play();
    logic [DRAW_W-1:0] eps;
    logic [DRAW_W-1:0] step;
    logic [4:0]        arms;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 4))
        0: eps = '0;
        1: eps = DRAW_MAX;
        2: eps = 16'd6554;
        default: eps = DRAW_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: step = '0;
        1: step = DRAW_MAX;
        2: step = 16'd1;
        default: step = DRAW_W'($urandom);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        arms = 5'($urandom_range(0, 31));
      end else begin
        arms = 5'($urandom_range(1, 16));
      end
      program_agent(eps, 1'($urandom_range(0, 1)), step, arms);
      gaps_on   = (phase % 4 != 3) && (phase != 7);
      stalls_on = gaps_on;
      for (int i = 0; i < 150; i++) begin
        send_pull(random_pull());
      end
      settle_agent();
    end
  endtask

  task automatic check_choice();
    choice_t got;
    choice_t want;
    got.chosen_arm    = rsp_ch.chosen_arm;
    got.explored      = rsp_ch.explored;
    got.best_estimate = rsp_ch.best_estimate;
    result_count++;
    if (expected_choices.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("result beat %0d with no pull outstanding: arm %0d explored %0b best %0d",
                 result_count, got.chosen_arm, got.explored, $signed(got.best_estimate));
      end
    end else begin
      want = expected_choices.pop_front();
      if (got.chosen_arm !== want.chosen_arm || got.explored !== want.explored ||
          got.best_estimate !== want.best_estimate) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("result beat %0d: expected arm %0d explored %0b best %0d,",
                   result_count, want.chosen_arm, want.explored,
                   $signed(want.best_estimate));
          $display("  got arm %0d explored %0b best %0d",
                   got.chosen_arm, got.explored, $signed(got.best_estimate));
        end
      end
    end
  endtask

  // Result side: every accepted choice is checked against the oldest
  // prediction, and ready is dropped in random bursts while stalls are on.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) check_choice();
      if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left   <= $urandom_range(0, 10);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("epsilon_greedy_bandit_agent: mismatch");
      $finish;
    end
  end

  initial begin
    cfg_we              <= 1'b0;
    cfg_index           <= egb_pkg::CFG_EPSILON;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.reward_valid <= 1'b0;
    req_ch.reward       <= '0;
    req_ch.explore_draw <= '0;
    req_ch.arm_draw     <= '0;
    req_ch.tie_draw     <= '0;
    gaps_on             = 1'b1;
    stalls_on           = 1'b1;

    // Shadow state matches the agent right after reset.
    for (int i = 0; i < NUM_ARMS; i++) begin
      arm_value[i] = '0;
      arm_pulls[i] = '0;
    end
    last_arm   = '0;
    have_last  = 1'b0;
    eps_q      = '0;
    const_step = 1'b0;
    step_q     = egb_pkg::STEP_SIZE_RESET;
    arms_cfg   = egb_pkg::ARMS_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_greedy_updates();
    test_exploration();
    test_arm_limits();
    test_single_arm();
    test_random_play();

    // A prediction still queued here means a result never came back.
    if (fail_count == 0 && expected_choices.size() == 0) begin
      $display("epsilon_greedy_bandit_agent: match");
    end else begin
      $display("epsilon_greedy_bandit_agent: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/egb_pkg.sv
src/egb_if.sv
src/egb_div.sv
src/egb_dp.sv
src/egb_ctrl.sv
src/epsilon_greedy_bandit_agent.sv
bench/epsilon_greedy_bandit_agent_tb.sv
